// ===== src/dtp_pkg.sv =====
// Shared types, character codes, status codes and the month-length table
// for the date-time string parser. No dependencies.
`timescale 1ns / 1ps

package dtp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Result status codes
    localparam logic [1:0] STATUS_ZERO  = 2'd0;
    localparam logic [1:0] STATUS_VALID = 2'd1;
    localparam logic [1:0] STATUS_MINUS = 2'd2;

    // Field limits
    localparam logic [31:0] YEAR_BASE  = 32'd2000;
    localparam logic [2:0]  NUM_FIELDS = 3'd6;
    localparam logic [7:0]  MONTH_MAX  = 8'd12;
    localparam logic [7:0]  HOUR_MAX   = 8'd23;
    localparam logic [7:0]  MINSEC_MAX = 8'd59;
    localparam logic [7:0]  FEB        = 8'd2;
    localparam logic [7:0]  LEAP_DAY   = 8'd29;

    // Gathered numbers of one string, handed over at the terminating byte
    typedef struct packed {
        logic       valid;
        logic       minus;
        logic [2:0] count;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_finish;

    // Days per month, February with 29; entry 0 and codes above 12 give 0
    function automatic logic [7:0] month_len(input logic [3:0] mo);
        logic [7:0] len;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 8'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 8'd30;
            4'd2:                                       len = 8'd29;
            default:                                    len = 8'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/dtp_if.sv =====
// Valid/ready channel interfaces for the parser: input bytes and date results.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

interface dtp_char_if;
    import dtp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dtp_date_if;
    import dtp_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] year_offset;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    modport source (output valid, output status, output year_offset, output month_out,
                    output day_out, output hour_out, output minute_out,
                    output second_out, input ready);
    modport sink   (input valid, input status, input year_offset, input month_out,
                    input day_out, input hour_out, input minute_out,
                    input second_out, output ready);
endinterface

// ===== src/datetime_string_parser_top.sv =====
// Date-time string parser, top level: input register, parse stage, result register.
// Depends on dtp_pkg, dtp_if, dtp_input_reg, dtp_parse_core, dtp_result_reg.
//
// Usage:
//   i_char carries the string one byte per transfer (valid/ready); a zero byte
//   ends the string. Digit runs give year, month, day, hour, minute, second;
//   any other byte separates them. o_date carries one result per string,
//   issued for the zero byte: status (0 invalid, 1 valid, 2 leading minus)
//   and the date fields, which are zero unless status is 1.
//   Throughput: one byte per cycle, set by the single parse stage, which
//   does a multiply by ten and add on the 32-bit accumulator per byte.
//   Result path: the terminating byte is held in the input register, then its
//   result is stored in the result register, from which o_date offers it.
//   Stalls: when a result waits on o_date, the parse stage holds its byte
//   and i_char.ready drops once the input register is full; non-terminating
//   bytes still flow while the result register is free or being emptied.
//   Reset (i_rst_n low, synchronous) empties both registers and clears the
//   parser so the next byte starts a new string.
`timescale 1ns / 1ps

module datetime_string_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtp_char_if.sink     i_char,
    dtp_date_if.source   o_date
);
    import dtp_pkg::*;

    logic       in_valid;
    logic [7:0] in_char;
    logic       res_free;
    logic       fire;
    t_finish    finish;

    // Parse a byte whenever one is held and the result register can take a result
    assign fire = in_valid && res_free;

    dtp_input_reg u_input_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_char  (in_char)
    );

    dtp_parse_core u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_char   (in_char),
        .o_finish (finish)
    );

    dtp_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_finish (finish),
        .o_free   (res_free),
        .o_date   (o_date)
    );

endmodule

// ===== src/dtp_input_reg.sv =====
// Input register for the byte channel; holds one byte until the parse stage
// takes it. Depends on dtp_pkg and dtp_if.
`timescale 1ns / 1ps

module dtp_input_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtp_char_if.sink      i_char,
    input  logic          i_take,
    output logic          o_valid,
    output logic [7:0]    o_char
);
    import dtp_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;

    // Free when empty or when the held byte leaves this cycle
    assign i_char.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

// ===== src/dtp_parse_core.sv =====
// Parse stage: gathers digit runs into the six numbers and flags the end of
// each string. Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_char,
    output dtp_pkg::t_finish   o_finish
);
    import dtp_pkg::*;

    logic [31:0] r_acc,    n_acc;
    logic        r_digits, n_digits;
    logic [2:0]  r_count,  n_count;
    logic        r_start,  n_start;
    logic        r_ignore, n_ignore;
    logic        r_minus,  n_minus;
    logic [7:0]  r_year,   n_year;
    logic [7:0]  r_month,  n_month;
    logic [7:0]  r_day,    n_day;
    logic [7:0]  r_hour,   n_hour;
    logic [7:0]  r_minute, n_minute;
    logic [7:0]  r_second, n_second;

    logic        is_digit;
    logic        active;
    logic [31:0] acc_x10;
    logic [7:0]  year_val;

    assign is_digit = i_char inside {[CHAR_ZERO:CHAR_NINE]};
    assign active   = !r_ignore && !r_minus;
    assign acc_x10  = (r_acc << 3) + (r_acc << 1) + {28'd0, i_char[3:0]};
    assign year_val = (r_acc >= YEAR_BASE) ? (r_acc[7:0] - YEAR_BASE[7:0]) : r_acc[7:0];

    // Next state for one byte
    always_comb begin
        n_acc    = r_acc;
        n_digits = r_digits;
        n_count  = r_count;
        n_start  = r_start;
        n_ignore = r_ignore;
        n_minus  = r_minus;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        o_finish = '0;

        if (i_fire) begin
            n_start = 1'b0;
            if (r_start && i_char == CHAR_MINUS) begin
                n_minus = 1'b1;
            end else if (is_digit) begin
                if (active) begin
                    n_acc    = acc_x10;
                    n_digits = 1'b1;
                end
            end else begin
                // Separator closes a digit run
                if (active && r_digits) begin
                    case (r_count)
                        3'd0:    n_year   = year_val;
                        3'd1:    n_month  = r_acc[7:0];
                        3'd2:    n_day    = r_acc[7:0];
                        3'd3:    n_hour   = r_acc[7:0];
                        3'd4:    n_minute = r_acc[7:0];
                        3'd5:    n_second = r_acc[7:0];
                        default: ;
                    endcase
                    if (r_count < NUM_FIELDS) begin
                        n_count = r_count + 3'd1;
                    end
                    n_acc    = '0;
                    n_digits = 1'b0;
                    if (n_count >= NUM_FIELDS) begin
                        n_ignore = 1'b1;
                    end
                end
                // Terminator: hand over the numbers and clear for the next string
                if (i_char == CHAR_NUL) begin
                    o_finish.valid  = 1'b1;
                    o_finish.minus  = n_minus;
                    o_finish.count  = n_count;
                    o_finish.year   = n_year;
                    o_finish.month  = n_month;
                    o_finish.day    = n_day;
                    o_finish.hour   = n_hour;
                    o_finish.minute = n_minute;
                    o_finish.second = n_second;
                    n_acc    = '0;
                    n_digits = 1'b0;
                    n_count  = '0;
                    n_start  = 1'b1;
                    n_ignore = 1'b0;
                    n_minus  = 1'b0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_digits <= 1'b0;
            r_count  <= '0;
            r_start  <= 1'b1;
            r_ignore <= 1'b0;
            r_minus  <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_count  <= n_count;
            r_start  <= n_start;
            r_ignore <= n_ignore;
            r_minus  <= n_minus;
        end
    end

    // Stored numbers; only read once all six are rewritten
    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
    end

endmodule

// ===== src/dtp_result_reg.sv =====
// Range check, leap-day fix-up and the result register on the date channel.
// Depends on dtp_pkg and dtp_if.
`timescale 1ns / 1ps

module dtp_result_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtp_pkg::t_finish   i_finish,
    output logic               o_free,
    dtp_date_if.source         o_date
);
    import dtp_pkg::*;

    logic       r_valid;
    logic [1:0] r_status;
    logic [7:0] r_year;
    logic [3:0] r_month;
    logic [4:0] r_day;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic [5:0] r_second;

    logic [1:0] n_status;
    logic [7:0] n_year;
    logic [3:0] n_month;
    logic [4:0] n_day;
    logic [4:0] n_hour;
    logic [5:0] n_minute;
    logic [5:0] n_second;
    logic       ok;
    logic       bad_leap;

    assign o_free = !r_valid || o_date.ready;

    assign ok = (i_finish.count == NUM_FIELDS)
             && (i_finish.month >= 8'd1) && (i_finish.month <= MONTH_MAX)
             && (i_finish.day >= 8'd1)
             && (i_finish.day <= month_len(i_finish.month[3:0]))
             && (i_finish.hour <= HOUR_MAX)
             && (i_finish.minute <= MINSEC_MAX)
             && (i_finish.second <= MINSEC_MAX);

    // 29 February of a year offset that is not a multiple of four rolls to 1 March
    assign bad_leap = (i_finish.month == FEB) && (i_finish.day == LEAP_DAY)
                   && (i_finish.year[1:0] != 2'b00);

    always_comb begin
        n_status = STATUS_ZERO;
        n_year   = '0;
        n_month  = '0;
        n_day    = '0;
        n_hour   = '0;
        n_minute = '0;
        n_second = '0;
        if (i_finish.minus) begin
            n_status = STATUS_MINUS;
        end else if (ok) begin
            n_status = STATUS_VALID;
            n_year   = i_finish.year;
            n_month  = bad_leap ? 4'd3 : i_finish.month[3:0];
            n_day    = bad_leap ? 5'd1 : i_finish.day[4:0];
            n_hour   = i_finish.hour[4:0];
            n_minute = i_finish.minute[5:0];
            n_second = i_finish.second[5:0];
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_finish.valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_finish.valid) begin
            r_status <= n_status;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    assign o_date.valid       = r_valid;
    assign o_date.status      = r_status;
    assign o_date.year_offset = r_year;
    assign o_date.month_out   = r_month;
    assign o_date.day_out     = r_day;
    assign o_date.hour_out    = r_hour;
    assign o_date.minute_out  = r_minute;
    assign o_date.second_out  = r_second;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for datetime_string_parser_top: directed strings, then random ones.
// Each accepted byte runs through a local parser model; every result is compared field by field.
// Depends on dtp_pkg, dtp_if and the RTL under src.
`timescale 1ns / 1ps

module tb;
    import dtp_pkg::*;

    localparam int unsigned TOTAL_ITEMS  = 600;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DIR_ROWS     = 20;

    // Days per month, February with 29; month m sits at bits [8*m +: 8]
    localparam logic [8*13-1:0] MONTH_DAYS = {8'd31, 8'd30, 8'd31, 8'd30, 8'd31, 8'd31,
                                              8'd30, 8'd31, 8'd30, 8'd31, 8'd29, 8'd31,
                                              8'd0};

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } date_t;

    // Result fixed by hand for a directed row, or left to the parser model
    typedef struct {
        bit    fixed;
        date_t value;
    } pin_t;

    localparam date_t NO_DATE    = '0;
    localparam date_t MINUS_DATE = {STATUS_MINUS, 34'd0};

    logic i_clk;
    logic i_rst_n;

    dtp_char_if char_bus ();
    dtp_date_if date_bus ();

    datetime_string_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_date  (date_bus)
    );

    // Directed strings; a zero byte is appended when each is sent
    string dir_text [DIR_ROWS] = '{
        "",
        "-",
        "-1/2/3 4:5:6",
        "0/1/1 0:0:0",
        "2255/12/31 23:59:59",
        "2001-2-29 0:0:0",
        "4/2/29 1:2:3",
        "1/13/1 0:0:0",
        "1/0/1 0:0:0",
        "1/4/31 0:0:0",
        "1/4/0 0:0:0",
        "1/1/1 24:0:0",
        "1/1/1 0:60:0",
        "1/1/1 0:0:60",
        "1/2/3",
        "1/2/3/4/5/6/7x-9",
        "99999999999/1/1 1:1:1",
        "7\2007\3777\2777\2017\1777",
        "1999/1/1 0:0:0",
        ":;12..3..4  5\t6 7 "
    };
    bit dir_fixed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1,
                                 1, 1, 1, 1, 1, 0, 0, 0, 0, 0};
    date_t dir_result [DIR_ROWS] = '{
        NO_DATE,
        MINUS_DATE,
        MINUS_DATE,
        {STATUS_VALID, 8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0},
        {STATUS_VALID, 8'd255, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
        {STATUS_VALID, 8'd1, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0},
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE,
        NO_DATE
    };

    // Parser model state
    logic [31:0] acc_value;
    logic        run_has_digit;
    logic [2:0]  fields_stored;
    logic [7:0]  field_val [0:5];
    logic        next_is_first;
    logic        skip_rest;
    logic        minus_lead;

    date_t       expected_dates [$];
    pin_t        row_pins [$];
    logic [7:0]  pending_text [$];

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_accepted = 0;
    int unsigned strings_sent = 0;
    int unsigned hold_offs = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          sender_steady = 0;
    bit          hold_off_req = 0;

    // Clock and the single reset pulse
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [7:0] days_in_month(input logic [7:0] mo);
        logic [7:0] len;
        len = 8'd0;
        if (mo >= 8'd1 && mo <= 8'd12) len = MONTH_DAYS[mo[3:0] * 8 +: 8];
        return len;
    endfunction

    function automatic void clear_parser();
        acc_value     = '0;
        run_has_digit = 1'b0;
        fields_stored = '0;
        for (int i = 0; i < 6; i++) field_val[i] = '0;
        next_is_first = 1'b1;
        skip_rest     = 1'b0;
        minus_lead    = 1'b0;
    endfunction

    // Close the current digit run into the next field
    function automatic void store_field();
        logic [31:0] v;
        v = acc_value;
        if (fields_stored == 3'd0 && v >= YEAR_BASE) v = v - YEAR_BASE;
        if (fields_stored < NUM_FIELDS) begin
            field_val[fields_stored] = v[7:0];
            fields_stored = fields_stored + 3'd1;
        end
        acc_value     = '0;
        run_has_digit = 1'b0;
        if (fields_stored >= NUM_FIELDS) skip_rest = 1'b1;
    endfunction

    // Advance the model by one byte; a zero byte queues one expected date
    function automatic void predict_byte(input logic [7:0] c);
        logic       first;
        logic       ok;
        logic [7:0] mo;
        logic [7:0] dy;
        date_t      d;
        pin_t       pin;
        first = next_is_first;
        next_is_first = 1'b0;
        if (first && c == CHAR_MINUS) begin
            minus_lead = 1'b1;
            return;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (!skip_rest && !minus_lead) begin
                acc_value     = acc_value * 32'd10 + {24'd0, c - CHAR_ZERO};
                run_has_digit = 1'b1;
            end
            return;
        end
        if (!skip_rest && !minus_lead && run_has_digit) store_field();
        if (c != CHAR_NUL) return;

        // End of string
        d = NO_DATE;
        if (minus_lead) begin
            d.status = STATUS_MINUS;
        end else begin
            mo = field_val[1];
            dy = field_val[2];
            ok = fields_stored == NUM_FIELDS && mo >= 8'd1 && mo <= MONTH_MAX &&
                 dy >= 8'd1 && dy <= days_in_month(mo) && field_val[3] <= HOUR_MAX &&
                 field_val[4] <= MINSEC_MAX && field_val[5] <= MINSEC_MAX;
            if (ok) begin
                // 29 February of a year offset not a multiple of four rolls over to 1 March
                if (mo == FEB && dy == LEAP_DAY && field_val[0][1:0] != 2'b00) begin
                    mo = 8'd3;
                    dy = 8'd1;
                end
                d.status = STATUS_VALID;
                d.year   = field_val[0];
                d.month  = mo[3:0];
                d.day    = dy[4:0];
                d.hour   = field_val[3][4:0];
                d.minute = field_val[4][5:0];
                d.second = field_val[5][5:0];
            end
        end
        clear_parser();
        if (row_pins.size() != 0) begin
            pin = row_pins.pop_front();
            if (pin.fixed) d = pin.value;
        end
        expected_dates.push_back(d);
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_date(input date_t got);
        date_t want;
        if (expected_dates.size() == 0) begin
            $display("%0t ns: result with nothing expected, expected none, actual %h",
                     $time, got);
            mismatch_count++;
            return;
        end
        want = expected_dates.pop_front();
        results_checked++;
        compare_field("status", want.status, got.status);
        compare_field("year_offset", want.year, got.year);
        compare_field("month_out", want.month, got.month);
        compare_field("day_out", want.day, got.day);
        compare_field("hour_out", want.hour, got.hour);
        compare_field("minute_out", want.minute, got.minute);
        compare_field("second_out", want.second, got.second);
    endfunction

    // Sample both channels at the falling edge: values are settled for the next rising edge
    always @(negedge i_clk) begin
        date_t got;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (char_bus.valid && char_bus.ready) begin
                predict_byte(char_bus.char_code);
                bytes_accepted++;
            end
            if (date_bus.valid && date_bus.ready) begin
                got.status = date_bus.status;
                got.year   = date_bus.year_offset;
                got.month  = date_bus.month_out;
                got.day    = date_bus.day_out;
                got.hour   = date_bus.hour_out;
                got.minute = date_bus.minute_out;
                got.second = date_bus.second_out;
                check_date(got);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d dates still pending", $time, expected_dates.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: segments of random stall patterns, plus long hold-offs on request
    initial begin
        int unsigned seg_left;
        int unsigned mode;
        seg_left = 0;
        mode = 0;
        date_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                hold_offs++;
                date_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (mode)
                    0, 1: date_bus.ready <= 1'b1;
                    2: date_bus.ready <= 1'($urandom_range(0, 1));
                    default: date_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one byte and hold it until transferred; bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || sender_steady) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= b;
        do @(negedge i_clk); while (!char_bus.ready);
        @(posedge i_clk);
    endtask

    // Send pending_text followed by the terminating zero byte
    task automatic send_string(input bit fixed, input date_t value);
        pin_t pin;
        pin.fixed = fixed;
        pin.value = value;
        row_pins.push_back(pin);
        strings_sent++;
        foreach (pending_text[i]) send_byte(pending_text[i]);
        send_byte(CHAR_NUL);
    endtask

    task automatic wait_for_results();
        char_bus.valid <= 1'b0;
        do @(posedge i_clk); while (expected_dates.size() != 0);
    endtask

    function automatic logic [7:0] pick_separator();
        logic [7:0] b;
        string      common;
        common = "/-: T.";
        if ($urandom_range(0, 1) == 1) begin
            b = common[$urandom_range(0, 5)];
        end else begin
            do b = 8'($urandom_range(1, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
        end
        return b;
    endfunction

    function automatic void add_separators();
        repeat (($urandom_range(0, 4) == 0) ? 2 : 1) pending_text.push_back(pick_separator());
    endfunction

    function automatic void append_number(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) pending_text.push_back(CHAR_ZERO);
        for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
    endfunction

    // Random string: mostly well-formed dates, the rest broken, minus-led, noise or empty
    function automatic void build_random_text();
        int unsigned kind;
        int unsigned vals [6];
        int unsigned nflds;
        kind = $urandom_range(0, 99);
        pending_text.delete();
        if (kind < 65) begin
            if ($urandom_range(0, 9) == 0) pending_text.push_back(pick_separator());
            case ($urandom_range(0, 3))
                0: vals[0] = 2000 + $urandom_range(0, 255);
                1: vals[0] = $urandom_range(0, 99);
                2: vals[0] = $urandom_range(1900, 2399);
                default: vals[0] = $urandom;
            endcase
            if ($urandom_range(0, 6) == 0) begin
                vals[1] = 2;
                vals[2] = 29;
            end else begin
                vals[1] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20)
                                                      : $urandom_range(1, 12);
                if ($urandom_range(0, 7) == 0 || vals[1] < 1 || vals[1] > 12)
                    vals[2] = $urandom_range(0, 40);
                else
                    vals[2] = $urandom_range(1, days_in_month(8'(vals[1])));
            end
            vals[3] = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
            vals[4] = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
            vals[5] = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
            for (int i = 0; i < 6; i++) begin
                if (i > 0) add_separators();
                append_number(vals[i]);
            end
            // Trailing bytes after the sixth number
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8)) pending_text.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 75) begin
            // Long digit run that wraps, and/or too few numbers
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(10, 16))
                    pending_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                add_separators();
            end
            nflds = $urandom_range(0, 5);
            for (int i = 0; i < nflds; i++) begin
                if (i > 0) add_separators();
                append_number($urandom_range(0, 99));
            end
        end else if (kind < 85) begin
            pending_text.push_back(CHAR_MINUS);
            repeat ($urandom_range(0, 12)) pending_text.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 16)) pending_text.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // Stimulus
    initial begin
        int unsigned items_sent;
        items_sent = 0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= CHAR_NUL;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            pending_text.delete();
            for (int i = 0; i < dir_text[r].len(); i++) pending_text.push_back(dir_text[r][i]);
            send_string(dir_fixed[r], dir_result[r]);
            items_sent += pending_text.size() + 1;
        end
        wait_for_results();

        // Random strings
        while (items_sent < TOTAL_ITEMS) begin
            sender_steady = (strings_sent % 12) < 3;
            if (strings_sent == DIR_ROWS + 8 || strings_sent == DIR_ROWS + 40) begin
                // Receiver holds off while short strings keep arriving: the block backs up
                hold_off_req = 1;
                repeat (16) begin
                    pending_text.delete();
                    case ($urandom_range(0, 2))
                        0: ;
                        1: pending_text.push_back(CHAR_MINUS);
                        default: for (int i = 0; i < 6; i++) begin
                            if (i > 0) pending_text.push_back(pick_separator());
                            pending_text.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
                        end
                    endcase
                    send_string(1'b0, NO_DATE);
                    items_sent += pending_text.size() + 1;
                end
            end
            if (strings_sent == DIR_ROWS + 24) wait_for_results();
            build_random_text();
            send_string(1'b0, NO_DATE);
            items_sent += pending_text.size() + 1;
        end

        // Drain and look for stray results
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d strings, %0d bytes transferred, %0d dates checked, %0d hold-offs",
                 strings_sent, bytes_accepted, results_checked, hold_offs);
        $display("Covered: empty, minus-led, range errors, leap roll-over, wraps, noise");
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
